// ----- src/b64d_pkg.sv -----
package b64d_pkg;

    // Character codes of interest
    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;  // '0'

    // Sextet offsets of the alphabet ranges
    localparam logic [5:0] SEXTET_LC_BASE  = 6'd26;
    localparam logic [5:0] SEXTET_DIG_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS     = 6'd62;
    localparam logic [5:0] SEXTET_SLASH    = 6'd63;

    // Output buffer: room for one full burst of three words plus slack
    localparam int OUT_BUF_DEPTH = 6;
    localparam int OUT_CNT_W     = $clog2(OUT_BUF_DEPTH + 1);

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        logic       decode_error;
    } result_t;

    // Map one character to its sextet; bad set for anything outside the alphabet
    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        logic [7:0] d;
        s.bad   = 1'b0;
        s.value = '0;
        d       = '0;
        if (ch inside {[8'h41:8'h5A]}) begin
            d       = ch - CHAR_UC_A;
            s.value = d[5:0];
        end
        else if (ch inside {[8'h61:8'h7A]}) begin
            d       = ch - CHAR_LC_A;
            s.value = d[5:0] + SEXTET_LC_BASE;
        end
        else if (ch inside {[8'h30:8'h39]}) begin
            d       = ch - CHAR_DIG_0;
            s.value = d[5:0] + SEXTET_DIG_BASE;
        end
        else if (ch == CHAR_PLUS) begin
            s.value = SEXTET_PLUS;
        end
        else if (ch == CHAR_SLASH) begin
            s.value = SEXTET_SLASH;
        end
        else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

    function automatic result_t byte_result(input logic [7:0] b);
        result_t r;
        r.data_byte      = b;
        r.byte_valid     = 1'b1;
        r.end_of_message = 1'b0;
        r.decode_error   = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/b64d_if.sv -----
// Character channel into the decoder
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// Decoded byte / status channel out of the decoder
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       decode_error;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, output decode_error, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, input decode_error, output ready);
endinterface

// ----- src/base64_stream_decoder_core.sv -----
// Base64 (RFC 4648) stream decoder. One character word is taken per cycle when
// ready; each character is decoded in the cycle it is accepted and the zero to
// three resulting words (bytes, or a single status word at end of message) are
// written into a six-entry output buffer that drains one word per ready cycle.
// Input ready is held high while the buffer has room for three more words, so
// with the output side always ready the block sustains one character per clock
// indefinitely (four characters yield three bytes). The last word of every
// message carries end_of_message; a bad message ends in one status-only word
// with decode_error set, and its bytes after the error are dropped.
module base64_stream_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    b64d_in_if.sink       char_in,
    b64d_out_if.source    byte_out
);

    localparam int DEPTH = b64d_pkg::OUT_BUF_DEPTH;
    localparam int CW    = b64d_pkg::OUT_CNT_W;

    // Decoder state
    logic [17:0] acc_reg,  acc_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  pad_reg,  pad_next;
    logic        err_reg,  err_next;

    // Output buffer
    b64d_pkg::result_t buf_reg  [DEPTH];
    b64d_pkg::result_t buf_next [DEPTH];
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic               accept;
    logic               pop;
    logic [CW-1:0]      base;
    b64d_pkg::sextet_t  sx;
    logic               is_pad;
    logic [23:0]        word;
    b64d_pkg::result_t  res [3];
    logic [1:0]         n_res;
    logic [17:0]        acc1;
    logic [1:0]         fill1;
    logic [1:0]         pad1;
    logic               err1;

    assign char_in.ready  = (cnt_reg <= CW'(DEPTH - 3));
    assign accept         = char_in.valid & char_in.ready;
    assign byte_out.valid = (cnt_reg != '0);
    assign pop            = byte_out.valid & byte_out.ready;
    assign base           = cnt_reg - CW'(pop);

    assign byte_out.data_byte      = buf_reg[0].data_byte;
    assign byte_out.byte_valid     = buf_reg[0].byte_valid;
    assign byte_out.end_of_message = buf_reg[0].end_of_message;
    assign byte_out.decode_error   = buf_reg[0].decode_error;

    assign sx     = b64d_pkg::sextet_of(char_in.char_code);
    assign is_pad = (char_in.char_code == b64d_pkg::CHAR_PAD);
    assign word   = {acc_reg, sx.value};

    // Character decode and end-of-message handling
    always_comb
    begin
        acc1  = acc_reg;
        fill1 = fill_reg;
        pad1  = pad_reg;
        err1  = err_reg;
        n_res = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            res[k] = '0;
        end

        if (!err_reg)
        begin
            if (is_pad)
            begin
                if (fill_reg >= 2'd2 && ({1'b0, fill_reg} + {1'b0, pad_reg}) < 3'd4
                    && pad_reg < 2'd2)
                begin
                    pad1 = pad_reg + 2'd1;
                end
                else
                begin
                    err1 = 1'b1;
                end
            end
            else if (sx.bad || pad_reg != 2'd0)
            begin
                err1 = 1'b1;
            end
            else if (fill_reg == 2'd3)
            begin
                res[0] = b64d_pkg::byte_result(word[23:16]);
                res[1] = b64d_pkg::byte_result(word[15:8]);
                res[2] = b64d_pkg::byte_result(word[7:0]);
                n_res  = 2'd3;
                acc1   = '0;
                fill1  = 2'd0;
            end
            else
            begin
                acc1  = {acc_reg[11:0], sx.value};
                fill1 = fill_reg + 2'd1;
            end
        end

        if (char_in.end_of_text)
        begin
            // flush the tail (no bytes were emitted above when a tail remains)
            if (!err1)
            begin
                case (fill1)
                    2'd3:
                    begin
                        res[0] = b64d_pkg::byte_result(acc1[17:10]);
                        res[1] = b64d_pkg::byte_result(acc1[9:2]);
                        n_res  = 2'd2;
                    end
                    2'd2:
                    begin
                        res[0] = b64d_pkg::byte_result(acc1[11:4]);
                        n_res  = 2'd1;
                    end
                    2'd1:
                    begin
                        err1 = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (err1 || n_res == 2'd0)
            begin
                res[0]              = '0;
                res[0].end_of_message = 1'b1;
                res[0].decode_error = err1;
                n_res               = 2'd1;
            end
            else
            begin
                case (n_res)
                    2'd1:    res[0].end_of_message = 1'b1;
                    2'd2:    res[1].end_of_message = 1'b1;
                    default: res[2].end_of_message = 1'b1;
                endcase
            end
        end
    end

    // Next decoder state: cleared at the end of each message
    always_comb
    begin
        acc_next  = acc_reg;
        fill_next = fill_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        if (accept)
        begin
            if (char_in.end_of_text)
            begin
                acc_next  = '0;
                fill_next = 2'd0;
                pad_next  = 2'd0;
                err_next  = 1'b0;
            end
            else
            begin
                acc_next  = acc1;
                fill_next = fill1;
                pad_next  = pad1;
                err_next  = err1;
            end
        end
    end

    // Buffer: shift out on pop, append new words behind the survivors
    always_comb
    begin
        logic [CW-1:0] off;
        off = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
            begin
                buf_next[i] = buf_reg[(i + 1) % DEPTH];
            end
            else
            begin
                buf_next[i] = buf_reg[i];
            end
            off = CW'(i) - base;
            if (accept && off < {{(CW-2){1'b0}}, n_res})
            begin
                buf_next[i] = res[off[1:0]];
            end
        end
        cnt_next = base + (accept ? {{(CW-2){1'b0}}, n_res} : '0);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= 2'd0;
            pad_reg  <= 2'd0;
            err_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Buffer payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

endmodule

// ----- src/b64d_checker.sv -----
module b64d_checker (
    input  logic          clk,
    input  logic          rst_n,
    b64d_in_if.sink       char_in,
    b64d_out_if.source    byte_out
);

    // A status-only word always closes a message
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && !byte_out.byte_valid) |-> byte_out.end_of_message)
        else $error("status-only word without end_of_message");

    // Errors are reported only in a status-only closing word
    a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && byte_out.decode_error)
            |-> (byte_out.end_of_message && !byte_out.byte_valid))
        else $error("decode_error on a non-final or data word");

    // Input back-pressure only comes from buffered output
    a_ready_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !char_in.ready |-> byte_out.valid)
        else $error("input stalled with nothing buffered");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && !byte_out.ready)
            |=> (byte_out.valid && $stable(byte_out.data_byte)
                 && $stable(byte_out.end_of_message)))
        else $error("stalled output word changed");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .char_in  (char_in),
    .byte_out (byte_out)
);
